/* hdl/frame_crc16_and_sum_macros.svh */
// Assertion macros shared by the frame CRC block.
`ifndef FRAME_CRC16_AND_SUM_MACROS_SVH
`define FRAME_CRC16_AND_SUM_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define FCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/fcs_pkg.sv */
// Shared types, constants and the CRC step function of the frame CRC block.
package fcs_pkg;

   localparam int FRAME_BITS_DEFAULT = 100;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int BYTE_W  = 8;
   localparam int CRC_W   = 16;
   localparam int BITS_W  = 7;
   localparam int SUM_W   = 32;
   localparam int FRAME_W = 20;
   localparam int IDX_W   = 3;

   localparam logic [CRC_W-1:0] GEN_POLY = 16'h1021;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              final_byte;
   } item_type;

   // Head of the input queue as seen by the engine.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PAD,
      ST_EMIT
   } eng_state_type;

   // One bit of the CRC shift register, message bit entering at the top.
   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic bit_in);
      logic top;
      logic [CRC_W-1:0] shifted;
      top     = crc[CRC_W-1] ^ bit_in;
      shifted = {crc[CRC_W-2:0], 1'b0};
      return top ? (shifted ^ GEN_POLY) : shifted;
   endfunction

endpackage

/* hdl/fcs_if.sv */
// Valid/ready channel interfaces for input bytes and frame results.
interface fcs_req_if;
   logic                        valid;
   logic                        ready;
   logic [fcs_pkg::BYTE_W-1:0]  data_byte;
   logic                        final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface fcs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fcs_pkg::CRC_W-1:0]    frame_crc;
   logic [fcs_pkg::FRAME_W-1:0]  frame_number;
   logic [fcs_pkg::SUM_W-1:0]    crc_sum;
   logic                         is_last;

   modport source (output valid, output frame_crc, output frame_number,
                   output crc_sum, output is_last, input ready);
   modport sink   (input valid, input frame_crc, input frame_number,
                   input crc_sum, input is_last, output ready);
endinterface

/* hdl/frame_crc16_and_sum.sv */
// Top level of the per-frame CRC-16 block with running CRC sum.
//
// The block cuts a byte stream, bits taken most significant first, into frames
// of FRAME_BITS bits (8 to 127, default 100; a frame boundary may fall inside a
// word) and returns one result word per frame: the CRC-16 (polynomial 0x1021,
// zero start, no reflection, no final xor), the frame index from zero wrapping
// at 2^20, and the sum of all frame CRCs of the message so far modulo 2^32.
// A word with final_byte set ends the message: a partial frame is padded with
// zero bits and returned with is_last set (a frame that ends exactly on the
// last bit carries is_last itself), and the next word starts a new message
// at index zero and sum zero. A word yields zero, one or two results.
// Timing: the CRC is bit-serial, one bit per clock while shifting; each word
// is first fetched from the queue and then shifted through bit by bit. Each
// finished frame passes through an emit state that loads the result register,
// and a final partial frame is padded with zero bits, up to FRAME_BITS - 1. A
// queue of QUEUE_DEPTH words takes input while the engine works, and the
// result register lets the engine carry on while a result waits to be taken;
// besides waiting for input words, the engine stalls only when a new frame is
// done and the previous result is still held.
module frame_crc16_and_sum #(
   parameter int FRAME_BITS  = fcs_pkg::FRAME_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = fcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fcs_req_if.sink    req_bus,
   fcs_rsp_if.source  rsp_bus
);

   // queue head handed from the front to the engine
   fcs_pkg::queue_head_type q_head;
   logic                    q_pop;

   // Accept words and hold them until the engine takes them.
   fcs_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // Shift bits through the CRC, close frames, pad and drive results.
   fcs_engine #(
      .FRAME_BITS (FRAME_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

/* hdl/fcs_front.sv */
// Input side: accept words into a short queue ahead of the CRC engine.
module fcs_front #(
   parameter int QUEUE_DEPTH = fcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   fcs_req_if.sink                 req_bus,
   output fcs_pkg::queue_head_type q_head,
   input  logic                    q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   fcs_pkg::item_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_bus.ready = (count_ff != CNT_FULL);
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = q_pop && (count_ff != '0);

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].data_byte  <= req_bus.data_byte;
         entry_ff[wr_ptr_ff].final_byte <= req_bus.final_byte;
      end
   end

endmodule

/* hdl/fcs_engine.sv */
// Back side: bit-serial CRC-16 over fixed-length frames, padding and result register.
`include "frame_crc16_and_sum_macros.svh"

module fcs_engine #(
   parameter int FRAME_BITS = fcs_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fcs_pkg::queue_head_type q_head,
   output logic                    q_pop,
   fcs_rsp_if.source               rsp_bus
);

   localparam logic [fcs_pkg::BITS_W-1:0] FRAME_LAST = fcs_pkg::BITS_W'(FRAME_BITS);

   fcs_pkg::eng_state_type state_ff, state_in;

   logic [fcs_pkg::CRC_W-1:0]   crc_ff, crc_in;
   logic [fcs_pkg::BITS_W-1:0]  bits_ff, bits_in;
   logic [fcs_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [fcs_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [fcs_pkg::BYTE_W-1:0]  shreg_ff, shreg_in;
   logic [fcs_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        final_ff, final_in;
   logic                        last_ff, last_in;
   logic                        more_ff, more_in;

   logic                        out_valid_ff, out_valid_in;
   logic [fcs_pkg::CRC_W-1:0]   out_crc_ff, out_crc_in;
   logic [fcs_pkg::FRAME_W-1:0] out_num_ff, out_num_in;
   logic [fcs_pkg::SUM_W-1:0]   out_sum_ff, out_sum_in;
   logic                        out_last_ff, out_last_in;

   logic                        cur_bit;
   logic [fcs_pkg::CRC_W-1:0]   crc_next;
   logic [fcs_pkg::BITS_W-1:0]  bits_next;
   logic [fcs_pkg::SUM_W-1:0]   sum_next;
   logic                        frame_done;
   logic                        out_free;

   assign cur_bit    = (state_ff == fcs_pkg::ST_PAD) ? 1'b0 : shreg_ff[fcs_pkg::BYTE_W-1];
   assign crc_next   = fcs_pkg::crc_step(crc_ff, cur_bit);
   assign bits_next  = bits_ff + 1'b1;
   assign sum_next   = sum_ff + fcs_pkg::SUM_W'(crc_ff);
   assign frame_done = (bits_next == FRAME_LAST);
   assign out_free   = !out_valid_ff || rsp_bus.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcs_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               state_in = fcs_pkg::ST_SHIFT;
            end
         end
         fcs_pkg::ST_SHIFT: begin
            if (frame_done) begin
               state_in = fcs_pkg::ST_EMIT;
            end else if (idx_ff == '0) begin
               state_in = final_ff ? fcs_pkg::ST_PAD : fcs_pkg::ST_IDLE;
            end
         end
         fcs_pkg::ST_PAD: begin
            if (frame_done) begin
               state_in = fcs_pkg::ST_EMIT;
            end
         end
         fcs_pkg::ST_EMIT: begin
            if (out_free) begin
               if (last_ff) begin
                  state_in = fcs_pkg::ST_IDLE;
               end else if (more_ff) begin
                  state_in = fcs_pkg::ST_SHIFT;
               end else begin
                  state_in = fcs_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = fcs_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      crc_in       = crc_ff;
      bits_in      = bits_ff;
      sum_in       = sum_ff;
      frame_in     = frame_ff;
      shreg_in     = shreg_ff;
      idx_in       = idx_ff;
      final_in     = final_ff;
      last_in      = last_ff;
      more_in      = more_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_crc_in   = out_crc_ff;
      out_num_in   = out_num_ff;
      out_sum_in   = out_sum_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         fcs_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               shreg_in = q_head.item.data_byte;
               final_in = q_head.item.final_byte;
               idx_in   = '1;
            end
         end
         fcs_pkg::ST_SHIFT: begin
            crc_in   = crc_next;
            bits_in  = bits_next;
            shreg_in = {shreg_ff[fcs_pkg::BYTE_W-2:0], 1'b0};
            idx_in   = idx_ff - 1'b1;
            if (frame_done) begin
               last_in = final_ff && (idx_ff == '0);
               more_in = (idx_ff != '0);
            end
         end
         fcs_pkg::ST_PAD: begin
            crc_in  = crc_next;
            bits_in = bits_next;
            if (frame_done) begin
               last_in = 1'b1;
               more_in = 1'b0;
            end
         end
         fcs_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_crc_in   = crc_ff;
               out_num_in   = frame_ff;
               out_sum_in   = sum_next;
               out_last_in  = last_ff;
               crc_in       = '0;
               bits_in      = '0;
               if (last_ff) begin
                  // end of message: start over
                  sum_in   = '0;
                  frame_in = '0;
                  final_in = 1'b0;
               end else begin
                  sum_in   = sum_next;
                  frame_in = frame_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.frame_crc    = out_crc_ff;
   assign rsp_bus.frame_number = out_num_ff;
   assign rsp_bus.crc_sum      = out_sum_ff;
   assign rsp_bus.is_last      = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcs_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         crc_ff       <= '0;
         bits_ff      <= '0;
         sum_ff       <= '0;
         frame_ff     <= '0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
         bits_ff      <= bits_in;
         sum_ff       <= sum_in;
         frame_ff     <= frame_in;
         final_ff     <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff    <= shreg_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      more_ff     <= more_in;
      out_crc_ff  <= out_crc_in;
      out_num_ff  <= out_num_in;
      out_sum_ff  <= out_sum_in;
      out_last_ff <= out_last_in;
   end

   `FCS_ASSERT(a_bits_in_range,
      bits_ff < FRAME_LAST || state_ff == fcs_pkg::ST_EMIT,
      "frame bit count reached frame length")
   `FCS_ASSERT_NEXT(a_emit_clears,
      state_ff == fcs_pkg::ST_EMIT && out_free,
      crc_ff == '0 && bits_ff == '0 && out_valid_ff,
      "emit did not clear frame state")
   `FCS_ASSERT_NEXT(a_last_restarts,
      state_ff == fcs_pkg::ST_EMIT && out_free && last_ff,
      frame_ff == '0 && sum_ff == '0 && state_ff == fcs_pkg::ST_IDLE,
      "message end did not restart")
   `FCS_ASSERT(a_pad_only_final, state_ff != fcs_pkg::ST_PAD || final_ff,
      "padding outside a final word")

endmodule
